// ----- src/whp_pkg.sv -----
// Shared types, constants and header layout for the WAV header parser.
package whp_pkg;

    localparam int OFFSET_BITS = 32;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [OFFSET_BITS:0]   reach_t;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_AUDIO   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_FIXED = 5'b00001,
        PH_CHUNK = 5'b00010,
        PH_CLM   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_AUDIO = 5'b10000
    } phase_t;

    // Tags as they sit in the little-endian shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_CLM  = 32'h206D_6C63;

    localparam logic [31:0] DEFAULT_MAX_RATE = 32'd200000;
    localparam logic [15:0] FMT_PCM          = 16'd1;
    localparam logic [15:0] MIN_FMT_SIZE     = 16'd16;
    localparam logic [15:0] MULTI_CH_ABOVE   = 16'd2;

    // Offset of the last byte of each fixed header field
    localparam offset_t OFS_RIFF_TAG  = offset_t'(3);
    localparam offset_t OFS_RIFF_SIZE = offset_t'(7);
    localparam offset_t OFS_WAVE_TAG  = offset_t'(11);
    localparam offset_t OFS_FMT_SIZE  = offset_t'(19);
    localparam offset_t OFS_FORMAT    = offset_t'(21);
    localparam offset_t OFS_CHANNELS  = offset_t'(23);
    localparam offset_t OFS_RATE      = offset_t'(27);
    localparam offset_t OFS_BITS      = offset_t'(35);

    localparam int FMT_BASE  = 20;
    localparam int CHUNK_HDR = 8;
    localparam offset_t REL_TAG  = offset_t'(3);
    localparam offset_t REL_SIZE = offset_t'(7);

    // A chunk header must end within the offset range
    localparam reach_t REACH_LIMIT = reach_t'({OFFSET_BITS{1'b1}}) - reach_t'(CHUNK_HDR);

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_MAX_RATE = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } beat_t;

    typedef struct packed {
        offset_t     byte_offset;
        offset_t     next_chunk;
        logic [31:0] field_shift;
        phase_t      phase;
        logic [15:0] channel_count;
        logic [31:0] rate_value;
        logic [15:0] width_value;
        logic [32:0] total_length;
        offset_t     audio_start;
        logic        failed;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        byte_offset:   '0,
        next_chunk:    '0,
        field_shift:   '0,
        phase:         PH_FIXED,
        channel_count: '0,
        rate_value:    '0,
        width_value:   '0,
        total_length:  '0,
        audio_start:   '0,
        failed:        1'b0
    };

endpackage

// ----- src/whp_if.sv -----
// Byte input and parse result channel interfaces.
interface whp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface whp_result_if;
    logic             valid;
    logic             ready;
    whp_pkg::status_t status;
    logic [15:0]      channels;
    logic             multichannel;
    logic [31:0]      rate_hz;
    logic [15:0]      bit_depth;
    logic [32:0]      stream_length;
    logic [31:0]      data_start;

    modport source (
        output valid, output status, output channels, output multichannel,
        output rate_hz, output bit_depth, output stream_length,
        output data_start, input ready
    );
    modport sink (
        input valid, input status, input channels, input multichannel,
        input rate_hz, input bit_depth, input stream_length,
        input data_start, output ready
    );
endinterface

// ----- src/whp_cfg.sv -----
// APB-style configuration register holding the sample rate limit.
module whp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [whp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [31:0]                  max_rate
);
    import whp_pkg::*;

    logic [31:0] max_rate_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_MAX_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg <= DEFAULT_MAX_RATE;
        end
        else if (wr_en)
        begin
            max_rate_reg <= pwdata;
        end
    end

    assign prdata   = (paddr == REG_MAX_RATE) ? max_rate_reg : '0;
    assign max_rate = max_rate_reg;

endmodule

// ----- src/whp_in_stage.sv -----
// Input register for incoming byte beats.
module whp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    whp_byte_if.sink       byte_in,
    output logic           out_valid,
    output whp_pkg::beat_t out_beat,
    input  logic           out_ready
);
    import whp_pkg::*;

    logic  valid_reg;
    beat_t beat_reg;

    assign byte_in.ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            beat_reg <= '{data_byte: byte_in.data_byte, first: byte_in.first};
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- src/whp_parser.sv -----
// Header parse state, per-byte update and result register.
module whp_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  whp_pkg::beat_t in_beat,
    output logic           in_ready,
    input  logic [31:0]    max_rate,
    whp_result_if.source   result
);
    import whp_pkg::*;

    parse_state_t state_reg;
    parse_state_t cur;
    parse_state_t nxt;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] out_channels_reg;
    logic        out_multi_reg;
    logic [31:0] out_rate_reg;
    logic [15:0] out_width_reg;
    logic [32:0] out_length_reg;
    logic [31:0] out_start_reg;

    logic        load;
    status_t     status_next;
    logic [31:0] fs_new;
    logic [15:0] hi16;
    logic [15:0] lo16;
    offset_t     rel;
    logic        past_start;
    reach_t      fmt_next;
    reach_t      clm_next;

    assign in_ready = !out_valid_reg || result.ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        cur         = in_beat.first ? PARSE_CLEAR : state_reg;
        nxt         = cur;
        fs_new      = {in_beat.data_byte, cur.field_shift[31:8]};
        hi16        = fs_new[31:16];
        lo16        = fs_new[15:0];
        rel         = cur.byte_offset - cur.next_chunk;
        past_start  = cur.byte_offset >= cur.next_chunk;
        fmt_next    = reach_t'(FMT_BASE) + reach_t'(lo16);
        clm_next    = reach_t'(cur.next_chunk) + reach_t'(CHUNK_HDR) + reach_t'(lo16);
        status_next = ST_HEADER;
        if (cur.failed)
        begin
            status_next = ST_INVALID;
        end
        else if (cur.phase == PH_AUDIO)
        begin
            status_next = ST_AUDIO;
        end
        else
        begin
            nxt.field_shift = fs_new;
            nxt.byte_offset = cur.byte_offset + offset_t'(1);
            case (cur.phase)
                PH_FIXED:
                begin
                    case (cur.byte_offset)
                        OFS_RIFF_TAG:
                        begin
                            if (fs_new != TAG_RIFF)
                                nxt.failed = 1'b1;
                        end
                        OFS_RIFF_SIZE:
                        begin
                            nxt.total_length = {1'b0, fs_new} + 33'(CHUNK_HDR);
                        end
                        OFS_WAVE_TAG:
                        begin
                            if (fs_new != TAG_WAVE)
                                nxt.failed = 1'b1;
                        end
                        OFS_FMT_SIZE:
                        begin
                            if (hi16 != '0 || lo16 < MIN_FMT_SIZE || fmt_next > REACH_LIMIT)
                                nxt.failed = 1'b1;
                            else
                                nxt.next_chunk = offset_t'(fmt_next);
                        end
                        OFS_FORMAT:
                        begin
                            if (hi16 != FMT_PCM)
                                nxt.failed = 1'b1;
                        end
                        OFS_CHANNELS:
                        begin
                            nxt.channel_count = hi16;
                        end
                        OFS_RATE:
                        begin
                            nxt.rate_value = fs_new;
                            if (fs_new > max_rate)
                                nxt.failed = 1'b1;
                        end
                        OFS_BITS:
                        begin
                            nxt.width_value = hi16;
                            if (!(hi16 inside {16'd8, 16'd16, 16'd32}))
                                nxt.failed = 1'b1;
                            nxt.phase = PH_CHUNK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_CHUNK:
                begin
                    if (past_start && rel == REL_TAG)
                    begin
                        if (fs_new == TAG_DATA)
                        begin
                            nxt.audio_start = cur.next_chunk + offset_t'(CHUNK_HDR);
                            nxt.phase       = PH_DATA;
                        end
                        else if (fs_new == TAG_CLM)
                            nxt.phase = PH_CLM;
                        else
                            nxt.failed = 1'b1;
                    end
                end
                PH_CLM:
                begin
                    if (past_start && rel == REL_SIZE)
                    begin
                        // skip by the low half of the chunk size only
                        if (clm_next > REACH_LIMIT)
                            nxt.failed = 1'b1;
                        else
                            nxt.next_chunk = offset_t'(clm_next);
                        nxt.phase = PH_CHUNK;
                    end
                end
                PH_DATA:
                begin
                    if (past_start && rel == REL_SIZE)
                        nxt.phase = PH_AUDIO;
                end
                default:
                begin
                end
            endcase
            status_next = nxt.failed ? ST_INVALID : ST_HEADER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                state_reg <= nxt;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg   <= status_next;
            out_channels_reg <= nxt.channel_count;
            out_multi_reg    <= nxt.channel_count > MULTI_CH_ABOVE;
            out_rate_reg     <= nxt.rate_value;
            out_width_reg    <= nxt.width_value;
            out_length_reg   <= nxt.total_length;
            out_start_reg    <= 32'(nxt.audio_start);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.channels      = out_channels_reg;
    assign result.multichannel  = out_multi_reg;
    assign result.rate_hz       = out_rate_reg;
    assign result.bit_depth     = out_width_reg;
    assign result.stream_length = out_length_reg;
    assign result.data_start    = out_start_reg;

    // failure is sticky until a new file starts
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        load && !in_beat.first && state_reg.failed |=> out_status_reg == ST_INVALID)
        else $error("invalid status not held");

    a_audio_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_AUDIO |-> !state_reg.failed)
        else $error("audio phase reached with failure set");

    a_audio_offset: assert property (@(posedge clk) disable iff (!rst_n)
        load && !in_beat.first && state_reg.phase == PH_AUDIO |=>
        $stable(state_reg.byte_offset))
        else $error("offset moved during audio");

    a_multi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_multi_reg == (out_channels_reg > MULTI_CH_ABOVE))
        else $error("multichannel flag disagrees with channel count");

endmodule

// ----- src/wav_header_parser.sv -----
// Top level of the WAV header parser.
// Feed the file one byte per beat, with first set on its opening byte; each byte
// gives exactly one result beat saying whether it is header (0), audio (1) or
// the header is invalid (2, held until the next first), together with the
// captured channel count, sample rate, bits per sample, stream length and
// audio start offset. One byte is taken every clock cycle while results are
// taken; its result is presented once the input register has held the byte
// and the combinational parse update has loaded the result register. A
// result that is not taken holds both registers, so the input stalls once two
// bytes are waiting. The sample rate limit is written at APB address 0
// (reset 200000) and must only be changed while idle.
module wav_header_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    whp_byte_if.sink                     byte_in,
    whp_result_if.source                 result_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [whp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import whp_pkg::*;

    logic        stage_valid;
    beat_t       stage_beat;
    logic        stage_ready;
    logic [31:0] max_rate;

    whp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_rate (max_rate)
    );

    whp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .out_valid (stage_valid),
        .out_beat  (stage_beat),
        .out_ready (stage_ready)
    );

    whp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid),
        .in_beat  (stage_beat),
        .in_ready (stage_ready),
        .max_rate (max_rate),
        .result   (result_out)
    );

endmodule
